FILE: rtl/wfsbp_pkg.sv
package wfsbp_pkg;

  typedef struct packed {
    logic [7:0] frame_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  record_kind;
    logic [47:0] source_address;
    logic [47:0] destination_address;
    logic [15:0] beacon_period;
    logic        privacy;
    logic [7:0]  channel;
    logic [5:0]  ssid_length;
    logic [7:0]  ssid_byte;
    logic [4:0]  ssid_index;
    logic        last_result;
  } out_item_t;

  localparam logic [2:0] KIND_ASSOC   = 3'd0;
  localparam logic [2:0] KIND_REASSOC = 3'd1;
  localparam logic [2:0] KIND_PROBE   = 3'd2;
  localparam logic [2:0] KIND_DATA    = 3'd3;
  localparam logic [2:0] KIND_BEACON  = 3'd4;

  // frame summary handed from the parser to the emitter
  typedef struct packed {
    logic [2:0]  kind;
    logic [47:0] src;
    logic [47:0] dst;
    logic [15:0] interval;
    logic        privacy;
    logic [7:0]  channel;
    logic [5:0]  ssid_len;
    logic [0:31][7:0] ssid;
  } frame_rec_t;

endpackage

FILE: rtl/wfsbp_parser.sv
module wfsbp_parser #(
  parameter int SSID_MAX = 32,
  parameter int FCS_MAX  = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  wfsbp_pkg::in_item_t   in_item,
  input  logic [2:0]            fcs_length,
  output logic                  closing,
  output logic                  rec_valid,
  output wfsbp_pkg::frame_rec_t rec
);

  typedef enum logic [2:0] {
    PH_HEADER, PH_FIXED, PH_EID, PH_ELEN, PH_BODY, PH_SKIP
  } phase_t;

  localparam int DL = (FCS_MAX > 0) ? FCS_MAX : 1;

  phase_t      phase;
  logic [7:0]  dline [DL];
  logic [11:0] byte_count;
  logic [15:0] fc;
  logic [47:0] ra, ta;
  logic [15:0] interval;
  logic        priv;
  logic [7:0]  chan;
  logic [0:31][7:0] ssid;
  logic [5:0]  ssid_len;
  logic [7:0]  eid;
  logic [8:0]  erem;
  logic [8:0]  eoff;

  logic [2:0]  lag;
  logic        exits;
  logic [7:0]  pb;
  logic [11:0] idx;
  logic [1:0]  ftype;
  logic [3:0]  fsub;
  logic        rec_hit;
  logic [2:0]  rec_kind;

  always_comb begin
    lag = (fcs_length > 3'(FCS_MAX)) ? 3'(FCS_MAX) : fcs_length;
    exits = byte_count >= 12'(lag);
    pb = in_item.frame_byte;
    for (int i = 0; i < DL; i++) begin
      if (lag == 3'(i + 1)) pb = dline[i];
    end
    idx = byte_count - 12'(lag);
    ftype = fc[3:2];
    fsub = fc[7:4];
    rec_hit = 1'b0;
    rec_kind = wfsbp_pkg::KIND_BEACON;
    if (phase == PH_SKIP) begin
      if (ftype == 2'd0 && fsub == 4'd0) begin
        rec_kind = wfsbp_pkg::KIND_ASSOC; rec_hit = 1'b1;
      end else if (ftype == 2'd0 && fsub == 4'd2) begin
        rec_kind = wfsbp_pkg::KIND_REASSOC; rec_hit = 1'b1;
      end else if (ftype == 2'd0 && fsub == 4'd4) begin
        rec_kind = wfsbp_pkg::KIND_PROBE; rec_hit = 1'b1;
      end else if (ftype == 2'd2 && fc[8]) begin
        rec_kind = wfsbp_pkg::KIND_DATA; rec_hit = 1'b1;
      end
    end else if (phase == PH_EID) begin
      rec_hit = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
      closing <= 1'b0;
      phase <= PH_HEADER;
      byte_count <= '0;
      fc <= '0; ra <= '0; ta <= '0; interval <= '0; priv <= 1'b0; chan <= '0;
      ssid <= '0; ssid_len <= '0; eid <= '0; erem <= '0; eoff <= '0;
      for (int i = 0; i < DL; i++) dline[i] <= '0;
    end else if (closing) begin
      // record built from state after the frame-end byte was parsed
      closing <= 1'b0;
      rec_valid <= rec_hit;
      rec.kind <= rec_kind;
      rec.src <= ta; rec.dst <= ra; rec.interval <= interval;
      rec.privacy <= priv; rec.channel <= chan; rec.ssid_len <= ssid_len;
      rec.ssid <= ssid;
      phase <= PH_HEADER;
      byte_count <= '0;
      fc <= '0; ra <= '0; ta <= '0; interval <= '0; priv <= 1'b0; chan <= '0;
      ssid <= '0; ssid_len <= '0; eid <= '0; erem <= '0; eoff <= '0;
      for (int i = 0; i < DL; i++) dline[i] <= '0;
    end else begin
      rec_valid <= 1'b0;
      if (in_valid) begin
        dline[0] <= in_item.frame_byte;
        for (int i = 1; i < DL; i++) dline[i] <= dline[i-1];
        if (byte_count != 12'hfff) byte_count <= byte_count + 12'd1;
        if (exits) begin
          unique case (phase)
            PH_HEADER: begin
              if (idx == 12'd0) fc[7:0] <= pb;
              if (idx == 12'd1) fc[15:8] <= pb;
              if (idx >= 12'd4 && idx < 12'd10) ra <= {ra[39:0], pb};
              if (idx >= 12'd10 && idx < 12'd16) ta <= {ta[39:0], pb};
              if (idx == 12'd23)
                phase <= (ftype == 2'd0 && fsub == 4'd8) ? PH_FIXED : PH_SKIP;
            end
            PH_FIXED: begin
              if (idx == 12'd32) interval <= {8'd0, pb};
              if (idx == 12'd33) interval[15:8] <= pb;
              if (idx == 12'd34) priv <= pb[4];
              if (idx == 12'd35) phase <= PH_EID;
            end
            PH_EID: begin
              eid <= pb;
              phase <= PH_ELEN;
            end
            PH_ELEN: begin
              erem <= {1'b0, pb};
              eoff <= '0;
              if (eid == 8'd0)
                ssid_len <= (pb < 8'(SSID_MAX)) ? pb[5:0] : 6'(SSID_MAX);
              phase <= (pb != 8'd0) ? PH_BODY : PH_EID;
            end
            PH_BODY: begin
              if (eid == 8'd0 && eoff < 9'(SSID_MAX)) ssid[eoff[4:0]] <= pb;
              if (eid == 8'd3 && eoff == 9'd0) chan <= pb;
              eoff <= eoff + 9'd1;
              erem <= erem - 9'd1;
              if (erem == 9'd1) phase <= PH_EID;
            end
            default: ;
          endcase
        end
        closing <= in_item.last_byte;
      end
    end
  end

endmodule

FILE: rtl/wfsbp_emitter.sv
module wfsbp_emitter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rec_valid,
  input  wfsbp_pkg::frame_rec_t rec_in,
  output logic                  busy,
  output logic                  empty,
  input  logic                  pop,
  output wfsbp_pkg::out_item_t  result
);

  // one-deep record queue plus the record being emitted
  logic                  q_valid;
  wfsbp_pkg::frame_rec_t q_rec;
  logic                  act;
  wfsbp_pkg::frame_rec_t cur;
  logic [5:0]            pos;
  logic                  bcn;
  logic [5:0]            slen;

  assign busy = q_valid;
  assign empty = !act;
  assign bcn = cur.kind == wfsbp_pkg::KIND_BEACON;
  assign slen = bcn ? cur.ssid_len : 6'd0;

  always_comb begin
    result.record_kind = cur.kind;
    result.source_address = cur.src;
    result.destination_address = cur.dst;
    result.beacon_period = bcn ? cur.interval : 16'd0;
    result.privacy = bcn & cur.privacy;
    result.channel = bcn ? cur.channel : 8'd0;
    result.ssid_length = slen;
    result.ssid_byte = (pos == 6'd0) ? 8'd0 : cur.ssid[5'(pos - 6'd1)];
    result.ssid_index = (pos == 6'd0) ? 5'd0 : 5'(pos - 6'd1);
    result.last_result = pos == slen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
      act <= 1'b0;
      pos <= '0;
    end else begin
      logic done;
      done = act && pop && (pos == slen);
      if (act && pop && !done) pos <= pos + 6'd1;
      if (rec_valid) begin
        q_valid <= 1'b1;
        q_rec <= rec_in;
      end
      if (!act || done) begin
        if (q_valid) begin
          act <= 1'b1; cur <= q_rec; pos <= '0;
          if (!rec_valid) q_valid <= 1'b0;
        end else begin
          act <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: rtl/wifi_frame_station_beacon_parser.sv
// Byte-wide 802.11 receive parser. Takes one frame byte per cycle (push/full) with a
// last-byte mark; the trailing fcs_length bytes (at most FCS_MAX) are delayed and
// ignored. At frame end it queues at most one record (management request, to-DS data
// or beacon); a beacon is followed by one result per SSID byte. Bytes flow at one per
// cycle, except that full is high in the cycle after each frame-end byte while
// the record is formed, and while a record sits in the queue slot, also behind one
// still read out; a record passes the parser's record register, then the queue slot.
// Write cfg only while idle.
module wifi_frame_station_beacon_parser #(
  parameter int SSID_MAX = 32,
  parameter int FCS_MAX  = 4
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  wfsbp_pkg::in_item_t  in_data,
  output logic                 empty,
  input  logic                 pop,
  output wfsbp_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [2:0]           cfg_data
);

  logic [2:0]            fcs_length;
  logic                  rec_valid;
  wfsbp_pkg::frame_rec_t rec;
  logic                  busy;
  logic                  closing;

  assign cfg_ready = 1'b1;
  // hold input while a frame is closing or the queue slot is still taken
  assign full = busy || closing;

  always_ff @(posedge clk) begin
    if (rst) fcs_length <= 3'd4;
    else if (cfg_valid) fcs_length <= cfg_data;
  end

  wfsbp_parser #(.SSID_MAX(SSID_MAX), .FCS_MAX(FCS_MAX)) u_parser (
    .clk, .rst, .in_valid(push && !full), .in_item(in_data),
    .fcs_length, .closing, .rec_valid, .rec
  );

  wfsbp_emitter u_emit (
    .clk, .rst, .rec_valid, .rec_in(rec), .busy, .empty, .pop, .result(out_data)
  );

`ifndef SYNTHESIS
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    rec_valid |-> !$past(busy)) else $error("record queue overrun");
  a_last_ok: assert property (@(posedge clk) disable iff (rst)
    (!empty && out_data.last_result) |-> (out_data.ssid_index == 5'(out_data.ssid_length - 6'd1)
      || out_data.ssid_length == 6'd0)) else $error("bad last mark");
  a_pop_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> !empty) else $error("result lost");
`endif

endmodule
